FILE: sv/fxs_pkg.sv
// ----------------------------------------------------------------------------
// fxs_pkg
// shared types and constants for the tag=value field scanner
// ----------------------------------------------------------------------------
package fxs_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int POS_W             = 12;
    localparam int TAG_W             = 32;
    localparam int POS_LIMIT_INT     = (MAX_MESSAGE_BYTES - 1) < 4095 ?
                                       (MAX_MESSAGE_BYTES - 1) : 4095;

    localparam logic [POS_W-1:0] POS_LIMIT   = POS_LIMIT_INT[POS_W-1:0];
    localparam logic [7:0]       BAR_BYTE    = 8'h7c;
    localparam logic [7:0]       EQUALS_BYTE = 8'h3d;
    localparam logic [7:0]       ZERO_CHAR   = 8'h30;
    localparam logic [7:0]       NINE_CHAR   = 8'h39;
    localparam logic [7:0]       DELIM_RESET = 8'h01;
    localparam logic [TAG_W-1:0] MSG_TYPE_TAG = 32'd35;

    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [TAG_W-1:0] field_tag;
        logic [POS_W-1:0] value_offset;
        logic [POS_W-1:0] value_length;
        logic             is_message_type;
    } out_word_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        begin
            if (p >= POS_LIMIT)
            begin
                r = POS_LIMIT;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

endpackage

FILE: sv/fxs_in_stage.sv
// ----------------------------------------------------------------------------
// fxs_in_stage
// input register for incoming message bytes
// ----------------------------------------------------------------------------
module fxs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fxs_pkg::in_word_t in_word,
    output logic              hold_valid,
    output fxs_pkg::in_word_t hold_word,
    input  logic              take
);
    import fxs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

FILE: sv/fxs_field_core.sv
// ----------------------------------------------------------------------------
// fxs_field_core
// per-byte field state update and result register
// ----------------------------------------------------------------------------
module fxs_field_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         field_delimiter,
    input  logic               hold_valid,
    input  fxs_pkg::in_word_t  hold_word,
    output logic               take,
    output logic               out_valid,
    input  logic               out_ready,
    output fxs_pkg::out_word_t out_word
);
    import fxs_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [TAG_W-1:0] acc_reg, acc_next;
    logic             has_reg, has_next;
    logic             inv_reg, inv_next;
    logic             eq_reg, eq_next;
    logic [POS_W-1:0] vs_reg, vs_next;
    logic             mtf_reg, mtf_next;
    logic             ovalid_reg, ovalid_next;
    out_word_t        oword_reg, oword_next;

    logic [7:0]       b;
    logic             last;
    logic             is_delim;
    logic             is_digit;
    logic [3:0]       digit;
    logic [TAG_W+3:0] acc_mul;
    logic             ovf;
    logic [TAG_W-1:0] acc_upd;
    logic             has_upd;
    logic             inv_upd;
    logic             eq_upd;
    logic [POS_W-1:0] vs_upd;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] end_pos;
    logic             emit;
    logic             is_type;

    assign take      = hold_valid && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign out_word  = oword_reg;

    always_comb
    begin
        b        = hold_word.data_byte;
        last     = hold_word.last_byte;
        is_delim = (b == field_delimiter) || (b == BAR_BYTE);
        is_digit = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
        digit    = 4'(b - ZERO_CHAR);
        pos_inc  = sat_inc(pos_reg);
        // tag * 10 + digit, overflow when above 32 bits
        acc_mul  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {32'b0, digit};
        ovf      = |acc_mul[TAG_W+3:TAG_W];

        acc_upd = acc_reg;
        has_upd = has_reg;
        inv_upd = inv_reg;
        eq_upd  = eq_reg;
        vs_upd  = vs_reg;
        if (!is_delim && !eq_reg)
        begin
            if (b == EQUALS_BYTE)
            begin
                eq_upd = 1'b1;
                vs_upd = pos_inc;
            end
            else
            begin
                has_upd = 1'b1;
                if (is_digit)
                begin
                    if (!inv_reg)
                    begin
                        if (ovf)
                        begin
                            inv_upd = 1'b1;
                        end
                        else
                        begin
                            acc_upd = acc_mul[TAG_W-1:0];
                        end
                    end
                end
                else
                begin
                    inv_upd = 1'b1;
                end
            end
        end

        end_pos = is_delim ? pos_reg : pos_inc;
        emit    = (is_delim || last) && eq_upd && has_upd && !inv_upd;
        is_type = (acc_upd == MSG_TYPE_TAG) && !mtf_reg;

        oword_next.field_tag       = acc_upd;
        oword_next.value_offset    = vs_upd;
        oword_next.value_length    = (end_pos >= vs_upd) ? (end_pos - vs_upd) : '0;
        oword_next.is_message_type = is_type;

        pos_next    = pos_reg;
        acc_next    = acc_reg;
        has_next    = has_reg;
        inv_next    = inv_reg;
        eq_next     = eq_reg;
        vs_next     = vs_reg;
        mtf_next    = mtf_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (take)
        begin
            ovalid_next = emit;
            if (is_delim || last)
            begin
                acc_next = '0;
                has_next = 1'b0;
                inv_next = 1'b0;
                eq_next  = 1'b0;
                vs_next  = '0;
            end
            else
            begin
                acc_next = acc_upd;
                has_next = has_upd;
                inv_next = inv_upd;
                eq_next  = eq_upd;
                vs_next  = vs_upd;
            end
            if (last)
            begin
                pos_next = '0;
                mtf_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc;
                if (emit && is_type)
                begin
                    mtf_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            acc_reg    <= '0;
            has_reg    <= 1'b0;
            inv_reg    <= 1'b0;
            eq_reg     <= 1'b0;
            vs_reg     <= '0;
            mtf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            has_reg    <= has_next;
            inv_reg    <= inv_next;
            eq_reg     <= eq_next;
            vs_reg     <= vs_next;
            mtf_reg    <= mtf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            oword_reg <= oword_next;
        end
    end

endmodule

FILE: sv/fix_tag_value_field_scanner.sv
// ----------------------------------------------------------------------------
// fix_tag_value_field_scanner
// splits a byte stream into tag=value fields and reports tag and value span
// ----------------------------------------------------------------------------
// a field result is valid in the cycle after its closing byte is taken
// throughput: one byte per cycle, set by the field state update
// a result held in the output register stalls the next byte until it is taken
// reset: rst_n clears all control and field state, delimiter returns to 0x01
// ----------------------------------------------------------------------------
module fix_tag_value_field_scanner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // data_byte
    input  logic                            s_axis_tlast,   // last_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fxs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // field_tag, value_offset, value_length
    output logic                            m_axis_tuser,   // is_message_type
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data        // field_delimiter
);
    import fxs_pkg::*;

    logic [7:0] delim_reg;
    in_word_t   in_word;
    in_word_t   hold_word;
    logic       hold_valid;
    logic       take;
    out_word_t  out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_valid)
        begin
            delim_reg <= cfg_data;
        end
    end

    assign in_word.data_byte = s_axis_tdata;
    assign in_word.last_byte = s_axis_tlast;

    fxs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .hold_valid (hold_valid),
        .hold_word  (hold_word),
        .take       (take)
    );

    fxs_field_core u_field_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .field_delimiter (delim_reg),
        .hold_valid      (hold_valid),
        .hold_word       (hold_word),
        .take            (take),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_word        (out_word)
    );

    assign m_axis_tdata = {out_word.value_length, out_word.value_offset, out_word.field_tag};
    assign m_axis_tuser = out_word.is_message_type;

endmodule
